### sv/lpd_pkg.sv
// Shared types, constants and tables for the lidar point preprocessing core.
// No dependencies; imported by every module of the block.
package lpd_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_BLIND = 2'd1,
        REG_KEEP  = 2'd2,
        REG_SCALE = 2'd3
    } t_reg_idx;

    // Sensor modes
    localparam logic [1:0] MODE_ROT   = 2'd0;
    localparam logic [1:0] MODE_PLAIN = 2'd1;

    // Defaults
    localparam int unsigned DEF_MAX_RINGS    = 64;
    localparam int unsigned DEF_COORD_BITS   = 24;
    localparam int unsigned DEF_CORDIC_ITERS = 16;
    localparam logic [31:0] SCALE_RESET      = 32'd65536000;

    // Timing constants
    localparam logic [28:0] DIV1000_MUL  = 29'd274877907;  // ceil(2^38 / 1000)
    localparam int unsigned DIV1000_SHR  = 38;
    localparam logic [11:0] US_MUL       = 12'd3125;       // 100000/23104 = 3125/722
    localparam logic [9:0]  US_DEN       = 10'd722;
    localparam logic [27:0] US_RECIP     = 28'd190358661;  // floor(2^37 / 722)
    localparam int unsigned US_RECIP_SHR = 37;
    localparam logic [16:0] TURN_US      = 17'd99722;
    localparam int signed   YAW_HALF     = 11520;
    localparam int signed   YAW_FULL     = 23040;
    localparam int signed   HALF_TURN16  = 180 * 65536;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] blind;
        logic [7:0]  keep;
        logic [31:0] scale;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_TIME,
        ST_CORD,
        ST_YAW,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } t_bstate;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [31:0] atan_deg16(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### sv/lpd_front.sv
// Front end: accepts points, tracks the decimation index, tags candidates.
// Depends on lpd_pkg.
module lpd_front import lpd_pkg::*; #(
    parameter int unsigned COORD_BITS = DEF_COORD_BITS,
    localparam int unsigned W = 3 * COORD_BITS + 57
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_push,
    input  logic                         i_frame_start,
    input  logic                         i_has_time,
    input  logic signed [COORD_BITS-1:0] i_x_mm,
    input  logic signed [COORD_BITS-1:0] i_y_mm,
    input  logic signed [COORD_BITS-1:0] i_z_mm,
    input  logic [15:0]                  i_intensity,
    input  logic [31:0]                  i_time_raw,
    input  logic [5:0]                   i_ring,
    input  logic                         i_q_full,
    output logic                         o_q_wr,
    output logic [W-1:0]                 o_q_data
);

    logic [7:0] r_idx, n_idx, cur_idx, keep;
    logic [8:0] idx_inc;
    logic       take;

    // Decimation index for this point and the next
    always_comb begin
        keep    = (i_cfg.keep == 8'd0) ? 8'd1 : i_cfg.keep;
        cur_idx = i_frame_start ? 8'd0 : r_idx;
        take    = (cur_idx == 8'd0);
        idx_inc = {1'b0, cur_idx} + 9'd1;
        n_idx   = (idx_inc >= {1'b0, keep}) ? 8'd0 : idx_inc[7:0];
    end

    assign o_q_wr   = i_push && !i_q_full;
    assign o_q_data = {take, i_frame_start, i_has_time, i_x_mm, i_y_mm, i_z_mm,
                       i_intensity, i_time_raw, i_ring};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 8'd0;
        end else if (o_q_wr) begin
            r_idx <= n_idx;
        end
    end

endmodule

### sv/lpd_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on lpd_pkg only through the common import style.
module lpd_fifo import lpd_pkg::*; #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_data,
    input  logic         i_rd,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");

    a_no_ghost_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !i_wr) |=> (r_cnt == 2'd0))
        else $error("queue filled without a write");

endmodule

### sv/lpd_back.sv
// Back end: range test, timing, CORDIC yaw, per-ring state and output register.
// Depends on lpd_pkg.
module lpd_back import lpd_pkg::*; #(
    parameter int unsigned MAX_RINGS    = DEF_MAX_RINGS,
    parameter int unsigned COORD_BITS   = DEF_COORD_BITS,
    parameter int unsigned CORDIC_ITERS = DEF_CORDIC_ITERS,
    localparam int unsigned W = 3 * COORD_BITS + 57
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_q_empty,
    input  logic [W-1:0]                 i_q_data,
    output logic                         o_q_rd,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic signed [COORD_BITS-1:0] o_out_x_mm,
    output logic signed [COORD_BITS-1:0] o_out_y_mm,
    output logic signed [COORD_BITS-1:0] o_out_z_mm,
    output logic [15:0]                  o_out_intensity,
    output logic [31:0]                  o_point_time_us
);

    localparam int unsigned C   = COORD_BITS;
    localparam int unsigned RAW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int unsigned CW  = C + 19;
    localparam int unsigned IW  = $clog2(CORDIC_ITERS + 1);
    localparam int unsigned R2W = 2 * C + 2;

    t_bstate r_state, n_state;

    // Item registers
    logic                 r_take, r_ht;
    logic signed [C-1:0]  r_x, r_y, r_z;
    logic [15:0]          r_inten;
    logic [31:0]          r_traw;
    logic [5:0]           r_ring;
    logic [R2W-1:0]       r_r2;
    logic [31:0]          r_b2;
    logic [63:0]          r_prod;
    logic                 r_pass;
    logic [31:0]          r_t;

    // CORDIC
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [31:0]   r_cz;
    logic [IW-1:0]        r_it;
    logic                 r_org;

    // Yaw to time
    logic [26:0]          r_n;
    logic [16:0]          r_qe;

    // Ring state
    logic [MAX_RINGS-1:0] r_started;
    logic [46:0]          r_mem [MAX_RINGS];
    logic [46:0]          r_rd;
    logic [RAW-1:0]       ring_idx;
    logic                 ring_ok;

    // Output register
    logic                 r_ov;
    logic                 load_in, load_out;

    // Combinational helpers
    logic signed [C-1:0]   sq_op;
    logic signed [2*C-1:0] sq;
    logic [31:0]           tmul_b;
    logic signed [CW-1:0]  x0, y0, dx, dy;
    logic signed [31:0]    zq, yaw;
    logic signed [15:0]    yaw_first;
    logic signed [16:0]    dd;
    logic [14:0]           d15;
    logic [54:0]           qprod;
    logic [26:0]           rem;
    logic [16:0]           qfix;
    logic [31:0]           tfin;
    logic                  time_sat;
    logic signed [C:0]     negx;
    logic signed [C-1:0]   oy_rot;
    logic                  mem_we;
    logic [46:0]           mem_wd;

    assign ring_idx = RAW'(r_ring);
    assign ring_ok  = (int'(r_ring) < int'(MAX_RINGS));
    assign load_in  = (r_state == ST_IDLE) && !i_q_empty;
    assign o_q_rd   = load_in;
    assign load_out = (r_state == ST_OUT) && (!r_ov || i_pop);
    assign o_empty  = !r_ov;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_SQX;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_SQZ;
            ST_SQZ:  n_state = ST_TIME;
            ST_TIME: begin
                if (i_cfg.mode == MODE_PLAIN && !r_ht) begin
                    n_state = ring_ok ? ST_CORD : ST_IDLE;
                end else if (i_cfg.mode == MODE_ROT) begin
                    n_state = (r_take && (r_r2 >= R2W'(r_b2))) ? ST_OUT : ST_IDLE;
                end else if (i_cfg.mode == MODE_PLAIN) begin
                    n_state = (r_take && (r_r2 > R2W'(r_b2))) ? ST_OUT : ST_IDLE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CORD: if (r_it == IW'(CORDIC_ITERS - 1)) n_state = ST_YAW;
            ST_YAW:  n_state = r_started[ring_idx] ? ST_DIV1 : ST_IDLE;
            ST_DIV1: n_state = ST_DIV2;
            ST_DIV2: n_state = r_pass ? ST_OUT : ST_IDLE;
            ST_OUT:  if (!r_ov || i_pop) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath helpers
    always_comb begin
        case (r_state)
            ST_SQX:  sq_op = r_x;
            ST_SQY:  sq_op = r_y;
            default: sq_op = r_z;
        endcase
        sq     = sq_op * sq_op;
        tmul_b = (i_cfg.mode == MODE_ROT) ? 32'(DIV1000_MUL) : i_cfg.scale;

        x0 = CW'(r_x) <<< 16;
        y0 = CW'(r_y) <<< 16;
        dx = r_cy >>> r_it;
        dy = r_cx >>> r_it;

        // Round to 1/64 degree and clamp
        zq  = (r_cz + 32'sd512) >>> 10;
        yaw = r_org ? 32'sd0
            : (zq > YAW_HALF) ? YAW_HALF
            : (zq < -YAW_HALF) ? -YAW_HALF : zq;

        // Angle travelled since the ring's first point
        yaw_first = $signed({r_rd[46], r_rd[46:32]});
        dd  = (yaw <= yaw_first) ? 17'(yaw_first) - yaw[16:0]
                                 : 17'(yaw_first) - yaw[16:0] + 17'(YAW_FULL);
        d15 = dd[14:0];

        qprod = {1'b0, r_n} * US_RECIP;
        rem   = r_n - 27'(r_qe * US_DEN);
        qfix  = (rem >= 27'(US_DEN)) ? r_qe + 17'd1 : r_qe;
        tfin  = (32'(qfix) < r_rd[31:0]) ? 32'(qfix) + 32'(TURN_US) : 32'(qfix);

        time_sat = (r_prod[63:48] != 16'd0);

        negx   = -(C+1)'(r_x);
        oy_rot = (negx > $signed({2'b00, {(C-1){1'b1}}})) ? {1'b0, {(C-1){1'b1}}}
                                                           : negx[C-1:0];

        mem_we = 1'b0;
        mem_wd = {yaw[14:0], 32'd0};
        if (r_state == ST_YAW && !r_started[ring_idx]) begin
            mem_we = 1'b1;
        end else if (r_state == ST_DIV2) begin
            mem_we = 1'b1;
            mem_wd = {r_rd[46:32], tfin};
        end
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[ring_idx] <= mem_wd;
        end
        r_rd <= r_mem[ring_idx];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= '0;
            r_ov      <= 1'b0;
            r_it      <= '0;
        end else begin
            r_state <= n_state;
            if (load_in && i_q_data[W-2]) begin
                r_started <= '0;
            end else if (r_state == ST_YAW) begin
                r_started[ring_idx] <= 1'b1;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (r_state == ST_CORD) begin
                r_it <= r_it + IW'(1);
            end else begin
                r_it <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_take  <= i_q_data[W-1];
            r_ht    <= i_q_data[W-3];
            r_x     <= i_q_data[54+3*C-1:54+2*C];
            r_y     <= i_q_data[54+2*C-1:54+C];
            r_z     <= i_q_data[54+C-1:54];
            r_inten <= i_q_data[53:38];
            r_traw  <= i_q_data[37:6];
            r_ring  <= i_q_data[5:0];
            r_r2    <= '0;
        end
        if (r_state == ST_SQX || r_state == ST_SQY || r_state == ST_SQZ) begin
            r_r2 <= r_r2 + R2W'($unsigned(sq));
        end
        if (r_state == ST_SQX) begin
            r_b2   <= i_cfg.blind * i_cfg.blind;
            r_prod <= r_traw * tmul_b;
        end
        if (r_state == ST_TIME) begin
            r_pass <= r_take && (r_r2 > R2W'(r_b2));
            if (i_cfg.mode == MODE_ROT) begin
                r_t <= 32'(r_prod[63:DIV1000_SHR]);
            end else begin
                r_t <= time_sat ? 32'hFFFF_FFFF : r_prod[47:16];
            end
            // CORDIC start, left half plane folded over
            r_org <= (r_x == '0) && (r_y == '0);
            if (r_x < 0) begin
                r_cx <= -x0;
                r_cy <= -y0;
                r_cz <= (r_y >= 0) ? HALF_TURN16 : -HALF_TURN16;
            end else begin
                r_cx <= x0;
                r_cy <= y0;
                r_cz <= 32'sd0;
            end
        end
        if (r_state == ST_CORD) begin
            if (r_cy >= 0) begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + atan_deg16(5'(r_it));
            end else begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - atan_deg16(5'(r_it));
            end
        end
        if (r_state == ST_YAW) begin
            r_n <= 27'(d15 * US_MUL);
        end
        if (r_state == ST_DIV1) begin
            r_qe <= qprod[US_RECIP_SHR+16:US_RECIP_SHR];
        end
        if (r_state == ST_DIV2) begin
            r_t <= tfin;
        end
        if (load_out) begin
            o_out_z_mm      <= r_z;
            o_out_intensity <= r_inten;
            o_point_time_us <= r_t;
            if (i_cfg.mode == MODE_ROT) begin
                o_out_x_mm <= r_y;
                o_out_y_mm <= oy_rot;
            end else begin
                o_out_x_mm <= r_x;
                o_out_y_mm <= r_y;
            end
        end
    end

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YAW) |-> (yaw <= YAW_HALF && yaw >= -YAW_HALF))
        else $error("yaw out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV2) |-> (rem < 27'(2 * US_DEN)))
        else $error("reciprocal estimate off by more than one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_ov && !i_pop) |=> (r_state == ST_OUT))
        else $error("result dropped while output register busy");

    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_q_rd)
        else $error("queue read while an item is in progress");

endmodule

### sv/lidar_point_decimate_and_timestamp_core.sv
// Top level of the lidar point preprocessing core: config registers and wiring.
// Depends on lpd_pkg, lpd_front, lpd_fifo and lpd_back.
//
// Usage:
//   Input channel: drive a point on the i_ fields and raise push; it transfers
//   on a clock edge where full is low. Results: while empty is low the oldest
//   kept point is on the o_ fields; it transfers on an edge where pop is high.
//   Configuration: i_cfg_we with i_cfg_idx/i_cfg_data writes one register at
//   the edge; the user must write only while the block is idle (not enforced).
//   Processing: one point at a time through the back-end sequencer, which runs
//   the range test and timing, and when the time is derived from the yaw also
//   the iterative CORDIC and the yaw-to-time division. A kept point then passes
//   through the output state to enter the output register.
//   A two-entry queue lets the input side keep transferring while the back end
//   works, and the output register lets the back end finish the next point
//   while a result waits; a stalled receiver holds the back end only once the
//   next kept point is ready to leave.
//   Reset: synchronous, clears the queue, the decimation index, the ring marks
//   and the output register, and loads the register defaults.
module lidar_point_decimate_and_timestamp_core import lpd_pkg::*; #(
    parameter int unsigned MAX_RINGS    = DEF_MAX_RINGS,
    parameter int unsigned COORD_BITS   = DEF_COORD_BITS,
    parameter int unsigned CORDIC_ITERS = DEF_CORDIC_ITERS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic                         i_frame_start,
    input  logic                         i_has_time,
    input  logic signed [COORD_BITS-1:0] i_x_mm,
    input  logic signed [COORD_BITS-1:0] i_y_mm,
    input  logic signed [COORD_BITS-1:0] i_z_mm,
    input  logic [15:0]                  i_intensity,
    input  logic [31:0]                  i_time_raw,
    input  logic [5:0]                   i_ring,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] o_out_x_mm,
    output logic signed [COORD_BITS-1:0] o_out_y_mm,
    output logic signed [COORD_BITS-1:0] o_out_z_mm,
    output logic [15:0]                  o_out_intensity,
    output logic [31:0]                  o_point_time_us
);

    localparam int unsigned W = 3 * COORD_BITS + 57;

    t_cfg         r_cfg;
    logic         q_wr, q_rd, q_full, q_empty;
    logic [W-1:0] q_wdata, q_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= MODE_ROT;
            r_cfg.blind <= 16'd0;
            r_cfg.keep  <= 8'd1;
            r_cfg.scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:  r_cfg.mode  <= i_cfg_data[1:0];
                REG_BLIND: r_cfg.blind <= i_cfg_data[15:0];
                REG_KEEP:  r_cfg.keep  <= i_cfg_data[7:0];
                REG_SCALE: r_cfg.scale <= i_cfg_data;
                default:   r_cfg.mode  <= r_cfg.mode;
            endcase
        end
    end

    assign full = q_full;

    lpd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_frame_start (i_frame_start),
        .i_has_time    (i_has_time),
        .i_x_mm        (i_x_mm),
        .i_y_mm        (i_y_mm),
        .i_z_mm        (i_z_mm),
        .i_intensity   (i_intensity),
        .i_time_raw    (i_time_raw),
        .i_ring        (i_ring),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_data      (q_wdata)
    );

    lpd_fifo #(.W(W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    lpd_back #(
        .MAX_RINGS    (MAX_RINGS),
        .COORD_BITS   (COORD_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rdata),
        .o_q_rd          (q_rd),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_x_mm      (o_out_x_mm),
        .o_out_y_mm      (o_out_y_mm),
        .o_out_z_mm      (o_out_z_mm),
        .o_out_intensity (o_out_intensity),
        .o_point_time_us (o_point_time_us)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for lidar_point_decimate_and_timestamp_core.
// Depends on lpd_pkg and the core; a built-in point predictor checks every kept point.
module tb import lpd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_DROP  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RINGS      = 64;
    localparam int CORD_STEPS = 16;
    localparam int SETTLE     = 120;
    localparam int WD_LIMIT   = 5000;
    localparam longint CMAX   = 64'sd8388607;

    typedef struct {
        bit                 frame_start;
        bit                 has_time;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [15:0]        inten;
        logic [31:0]        traw;
        logic [5:0]         ring;
    } t_point;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [15:0]        inten;
        logic [31:0]        t_us;
    } t_kept;

    typedef enum logic { ROW_CFG, ROW_PT } t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_reg_idx  idx;
        logic [31:0] data;
        t_point    pt;
        bit        typed;
        t_kept     kept;
    } t_row;

    // atan(2^-i) in 1/65536 degree
    localparam longint ATAN16 [CORD_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic               i_frame_start = 1'b0;
    logic               i_has_time = 1'b0;
    logic signed [23:0] i_x_mm = '0;
    logic signed [23:0] i_y_mm = '0;
    logic signed [23:0] i_z_mm = '0;
    logic [15:0]        i_intensity = '0;
    logic [31:0]        i_time_raw = '0;
    logic [5:0]         i_ring = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [23:0] o_out_x_mm;
    logic signed [23:0] o_out_y_mm;
    logic signed [23:0] o_out_z_mm;
    logic [15:0]        o_out_intensity;
    logic [31:0]        o_point_time_us;

    lidar_point_decimate_and_timestamp_core uut (.*);

    // Predictor state
    logic [1:0]  cfg_mode;
    logic [15:0] cfg_blind;
    logic [7:0]  cfg_keep;
    logic [31:0] cfg_scale;
    int unsigned frame_pos;
    bit          ring_seen [RINGS];
    int          ring_yaw0 [RINGS];
    longint      ring_tlast [RINGS];

    t_kept kept_q[$];
    int    err_cnt = 0;
    int    points_sent = 0;
    int    points_kept = 0;
    int    tx_idle = 0;
    int    rx_stall = 0;
    int    rx_hold = 0;
    int    wd_cnt = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // CORDIC yaw in 1/64 degree
    function automatic int yaw64_of(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        longint q;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            z = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORD_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN16[i];
            end else begin
                x -= dx; y += dy; z -= ATAN16[i];
            end
        end
        q = (z + 512) >>> 10;
        if (q > YAW_HALF) q = YAW_HALF;
        if (q < -YAW_HALF) q = -YAW_HALF;
        return int'(q);
    endfunction

    // Advance the point state; returns 1 with the kept point when one leaves
    function automatic bit keep_point(input t_point p, output t_kept k);
        longint x, y, z, r2, b2, t, d;
        longint unsigned prod;
        int unsigned step;
        bit take;
        int yaw;
        x = p.x; y = p.y; z = p.z;
        step = (cfg_keep == 0) ? 1 : cfg_keep;
        if (p.frame_start) begin
            frame_pos = 0;
            foreach (ring_seen[i]) ring_seen[i] = 1'b0;
        end
        take = (frame_pos == 0);
        frame_pos = (frame_pos + 1 >= step) ? 0 : frame_pos + 1;
        r2 = x * x + y * y + z * z;
        b2 = longint'(cfg_blind) * longint'(cfg_blind);
        k.z = p.z;
        k.inten = p.inten;
        if (cfg_mode == MODE_ROT) begin
            if (!take || r2 < b2) return 0;
            k.x = p.y;
            k.y = (-x > CMAX) ? CMAX[23:0] : 24'(-x);
            k.t_us = p.traw / 1000;
            return 1;
        end
        if (cfg_mode != MODE_PLAIN) return 0;
        k.x = p.x;
        k.y = p.y;
        if (p.has_time) begin
            prod = {32'd0, p.traw} * {32'd0, cfg_scale};
            t = longint'(prod >> 16);
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        end else begin
            yaw = yaw64_of(x, y);
            if (!ring_seen[p.ring]) begin
                ring_seen[p.ring] = 1'b1;
                ring_yaw0[p.ring] = yaw;
                ring_tlast[p.ring] = 0;
                return 0;
            end
            d = (yaw <= ring_yaw0[p.ring]) ? ring_yaw0[p.ring] - yaw
                                           : ring_yaw0[p.ring] - yaw + YAW_FULL;
            t = d * 100000 / 23104;
            if (t < ring_tlast[p.ring]) t += TURN_US;
            ring_tlast[p.ring] = t;
        end
        k.t_us = t[31:0];
        return take && r2 > b2;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE:  cfg_mode = data[1:0];
            REG_BLIND: cfg_blind = data[15:0];
            REG_KEEP:  cfg_keep = data[7:0];
            REG_SCALE: cfg_scale = data;
            default:   cfg_mode = cfg_mode;
        endcase
    endtask

    // Block until every kept point has left, then let dropped ones finish
    task automatic drain();
        while (kept_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // One point transfer; a typed expectation replaces the predicted one
    task automatic send(t_point p, bit typed, t_kept typed_k);
        t_kept k;
        while ($urandom_range(0, 99) < tx_idle) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        i_frame_start = p.frame_start;
        i_has_time = p.has_time;
        i_x_mm = p.x;
        i_y_mm = p.y;
        i_z_mm = p.z;
        i_intensity = p.inten;
        i_time_raw = p.traw;
        i_ring = p.ring;
        push = 1'b1;
        do @(posedge i_clk); while (full);
        points_sent++;
        if (keep_point(p, k)) kept_q = {kept_q, (typed ? typed_k : k)};
        else if (typed) kept_q = {kept_q, typed_k};
        @(negedge i_clk);
        push = 1'b0;
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return '0;
            3: return 24'($signed($urandom_range(0, 4000)) - 2000);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_point rand_point(bit frame_time);
        t_point p;
        p.frame_start = ($urandom_range(0, 39) == 0);
        p.has_time = ($urandom_range(0, 19) == 0) ? !frame_time : frame_time;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        p.inten = 16'($urandom);
        p.traw = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
        p.ring = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        return p;
    endfunction

    task automatic rand_config();
        int m;
        m = $urandom_range(0, 9);
        write_reg(REG_MODE, 32'((m < 4) ? MODE_ROT : (m < 8) ? MODE_PLAIN :
                                (m == 8) ? MODE_DROP : MODE_SPARE));
        case ($urandom_range(0, 9))
            0:       write_reg(REG_BLIND, 32'd65535);
            1:       write_reg(REG_BLIND, 32'($urandom_range(0, 65535)));
            default: write_reg(REG_BLIND, 32'($urandom_range(0, 3000)));
        endcase
        case ($urandom_range(0, 9))
            0:       write_reg(REG_KEEP, 32'd255);
            1:       write_reg(REG_KEEP, 32'd0);
            2:       write_reg(REG_KEEP, 32'($urandom_range(1, 255)));
            default: write_reg(REG_KEEP, 32'($urandom_range(1, 4)));
        endcase
        case ($urandom_range(0, 3))
            0: write_reg(REG_SCALE, SCALE_RESET);
            1: write_reg(REG_SCALE, ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0);
            default: write_reg(REG_SCALE, $urandom);
        endcase
    endtask

    // Result side: check at the rising edge, steer pop at the falling edge
    initial begin
        t_kept e;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                points_kept++;
                if (kept_q.size() == 0) begin
                    $error("unexpected kept point x=%0d", o_out_x_mm);
                    err_cnt++;
                end else begin
                    e = kept_q.pop_front();
                    if (o_out_x_mm !== e.x) begin
                        $error("out_x_mm exp %0d got %0d", e.x, o_out_x_mm); err_cnt++;
                    end
                    if (o_out_y_mm !== e.y) begin
                        $error("out_y_mm exp %0d got %0d", e.y, o_out_y_mm); err_cnt++;
                    end
                    if (o_out_z_mm !== e.z) begin
                        $error("out_z_mm exp %0d got %0d", e.z, o_out_z_mm); err_cnt++;
                    end
                    if (o_out_intensity !== e.inten) begin
                        $error("out_intensity exp %0d got %0d", e.inten, o_out_intensity);
                        err_cnt++;
                    end
                    if (o_point_time_us !== e.t_us) begin
                        $error("point_time_us exp %0d got %0d", e.t_us, o_point_time_us);
                        err_cnt++;
                    end
                end
            end
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                pop = 1'b0;
            end else begin
                pop = i_rst_n && ($urandom_range(0, 99) >= rx_stall);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) wd_cnt <= 0;
        else wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WD_LIMIT) begin
            $display("FAIL lidar_point_decimate_and_timestamp_core");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_row rows[$];
        t_row r;
        t_point p0;
        t_kept k0;
        bit frame_time;
        int idle_tx [4] = '{0, 65, 0, 29};
        int idle_rx [4] = '{0, 0, 65, 29};

        cfg_mode = MODE_ROT;
        cfg_blind = '0;
        cfg_keep = 8'd1;
        cfg_scale = SCALE_RESET;
        frame_pos = 0;
        foreach (ring_seen[i]) ring_seen[i] = 1'b0;

        p0 = '{1'b0, 1'b0, 24'sd0, 24'sd0, 24'sd0, 16'd0, 32'd0, 6'd0};
        k0 = '{24'sd0, 24'sd0, 24'sd0, 16'd0, 32'd0};
        r = '{ROW_PT, REG_MODE, 32'd0, p0, 1'b0, k0};

        // Reset defaults: rotation, time in ns / 1000
        r.pt = '{1'b1, 1'b0, 24'sd1, 24'sd2, 24'sd3, 16'd5, 32'd5000, 6'd0};
        r.typed = 1'b1; r.kept = '{24'sd2, -24'sd1, 24'sd3, 16'd5, 32'd5};
        rows = {rows, r};
        // Coordinate extremes, negation saturates
        r.pt = '{1'b0, 1'b0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 16'hFFFF,
                 32'hFFFF_FFFF, 6'd63};
        r.kept = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 16'hFFFF, 32'd4294967};
        rows = {rows, r};
        r.pt = '{1'b0, 1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16'd0, 32'd999, 6'd1};
        r.kept = '{24'sh800000, 24'sh800001, 24'sh7FFFFF, 16'd0, 32'd0};
        rows = {rows, r};
        r.typed = 1'b0;
        // Blind zone: boundary passes in rotated mode only
        r.kind = ROW_CFG; r.idx = REG_BLIND; r.data = 32'd10; rows = {rows, r};
        r.kind = ROW_PT;
        r.pt = '{1'b0, 1'b0, 24'sd10, 24'sd0, 24'sd0, 16'd7, 32'd0, 6'd2};
        rows = {rows, r};
        r.pt.x = 24'sd9; rows = {rows, r};
        r.kind = ROW_CFG; r.idx = REG_MODE; r.data = 32'(MODE_PLAIN); rows = {rows, r};
        r.kind = ROW_PT; r.pt.x = 24'sd10; r.pt.has_time = 1'b1; rows = {rows, r};
        r.pt.x = 24'sd11; r.pt.traw = 32'd1; r.typed = 1'b1;
        r.kept = '{24'sd11, 24'sd0, 24'sd0, 16'd7, 32'd1000};
        rows = {rows, r};
        r.pt.traw = 32'hFFFF_FFFF;
        r.kept.t_us = 32'hFFFF_FFFF;
        rows = {rows, r};
        r.typed = 1'b0;
        r.kind = ROW_CFG; r.idx = REG_SCALE; r.data = 32'd0; rows = {rows, r};
        r.kind = ROW_PT; rows = {rows, r};
        // Yaw-derived time: first point of a ring, wrap, backwards time, origin
        r.pt = '{1'b1, 1'b0, 24'sd100, 24'sd0, 24'sd0, 16'd1, 32'd0, 6'd0};
        rows = {rows, r};
        r.pt.frame_start = 1'b0; r.pt.x = 24'sd0; r.pt.y = 24'sd100; rows = {rows, r};
        r.pt.x = 24'sd100; r.pt.y = -24'sd1; rows = {rows, r};
        r.pt.x = 24'sd0; r.pt.y = 24'sd0; r.pt.z = 24'sd50; rows = {rows, r};
        r.pt = '{1'b0, 1'b0, -24'sd100, 24'sd0, 24'sd0, 16'd2, 32'd0, 6'd63};
        rows = {rows, r};
        r.pt.y = -24'sd1; rows = {rows, r};
        // Decimation, zero factor, drop modes, register extremes
        r.kind = ROW_CFG; r.idx = REG_KEEP; r.data = 32'd3; rows = {rows, r};
        r.kind = ROW_PT; r.pt.has_time = 1'b1;
        repeat (4) rows = {rows, r};
        r.kind = ROW_CFG; r.idx = REG_KEEP; r.data = 32'd0; rows = {rows, r};
        r.kind = ROW_PT; rows = {rows, r};
        r.kind = ROW_CFG; r.idx = REG_MODE; r.data = 32'(MODE_DROP); rows = {rows, r};
        r.kind = ROW_PT; rows = {rows, r};
        r.kind = ROW_CFG; r.idx = REG_MODE; r.data = 32'(MODE_SPARE); rows = {rows, r};
        r.kind = ROW_PT; rows = {rows, r};
        r.kind = ROW_CFG; r.idx = REG_MODE; r.data = 32'(MODE_ROT); rows = {rows, r};
        r.idx = REG_BLIND; r.data = 32'd65535; rows = {rows, r};
        r.idx = REG_KEEP; r.data = 32'd255; rows = {rows, r};
        r.kind = ROW_PT; r.pt.x = 24'sh7FFFFF; rows = {rows, r};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                send(rows[i].pt, rows[i].typed, rows[i].kept);
            end
        end

        // Random phases over the idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle = idle_tx[ph];
            rx_stall = idle_rx[ph];
            for (int c = 0; c < 6; c++) begin
                drain();
                rand_config();
                frame_time = ($urandom_range(0, 1) != 0);
                if (ph == 0 && c == 2) begin
                    // long receiver hold while points keep coming
                    write_reg(REG_MODE, 32'(MODE_ROT));
                    write_reg(REG_BLIND, 32'd0);
                    write_reg(REG_KEEP, 32'd1);
                    rx_hold = 400;
                end
                repeat (70) send(rand_point(frame_time), 1'b0, k0);
            end
        end

        drain();
        if (kept_q.size() != 0) begin
            $error("%0d kept points never arrived", kept_q.size());
            err_cnt++;
        end
        $display("Sent %0d points over all modes, decimation and blind settings;",
                 points_sent);
        $display("%0d kept points checked, %0d mismatches.", points_kept, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS lidar_point_decimate_and_timestamp_core");
        end else begin
            $display("FAIL lidar_point_decimate_and_timestamp_core");
        end
        $finish;
    end
endmodule
